FILE: sv/lphs_pkg.sv
// Shared constants and request codes for the linear-probe hash set.
`default_nettype none
package lphs_pkg;

  localparam int unsigned TABLE_SIZE_DFLT = 128;
  localparam int unsigned KEY_W           = 16;
  localparam int unsigned SLOT_W          = 7;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

endpackage
`default_nettype wire

FILE: sv/lphs_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface lphs_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [lphs_pkg::KEY_W-1:0]     key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lphs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic                           inserted;
  logic                           table_full;
  logic [lphs_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, output found, output inserted, output table_full,
                  output slot, input ready);
  modport sink   (input valid, input found, input inserted, input table_full,
                  input slot, output ready);
endinterface
`default_nettype wire

FILE: sv/linear_probe_hash_set_core.sv
// Top level of the linear-probe hash set: slot memory, probe sequencer, response register.
`default_nettype none
// Open-addressing hash set, identity hash, linear probing over TABLE_SIZE slots
// held in one single-port-write, registered-read memory of {used, key}. After
// reset a clearing pass writes one slot per cycle, so no request is taken until
// every slot is cleared. A request is accepted, its key is reduced modulo
// TABLE_SIZE (reciprocal multiply, one correcting subtract), k slots are probed
// (one memory read per cycle, at most TABLE_SIZE slots), and the response
// register is loaded once it is free, so throughput is set by cluster length
// and table load. The response register frees the sequencer, which takes the
// next request while a response waits to be transferred.
module linear_probe_hash_set_core #(
  parameter int unsigned TABLE_SIZE = lphs_pkg::TABLE_SIZE_DFLT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lphs_req_if.sink    in_req,
  lphs_rsp_if.source  out_rsp
);

  localparam int unsigned AW    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned KW    = lphs_pkg::KEY_W;
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic           is_ins_r, is_ins_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [AW-1:0]  chk_addr_r, chk_addr_nxt;
  logic           chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic           res_found_r, res_found_nxt;
  logic           res_ins_r, res_ins_nxt;
  logic           res_full_r, res_full_nxt;
  logic [lphs_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_ins_r, out_full_r;
  logic [lphs_pkg::SLOT_W-1:0] out_slot_r;
  logic           out_load;

  logic           in_xfer;
  logic           mod_start, mod_done;
  logic [AW-1:0]  mod_rem;

  // slot memory: {used, key}
  logic [KW:0]    mem [TABLE_SIZE];
  logic [KW:0]    rdata_r;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [KW:0]    mem_wd;

  logic           rd_used;
  logic [KW-1:0]  rd_key;

  assign in_xfer   = in_req.valid && in_req.ready;
  assign mod_start = in_xfer;
  assign rd_used   = rdata_r[KW];
  assign rd_key    = rdata_r[KW-1:0];

  lphs_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_req.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[addr_r];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    is_ins_nxt    = is_ins_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_vld_nxt   = chk_vld_r;
    cnt_nxt       = cnt_r;
    res_found_nxt = res_found_r;
    res_ins_nxt   = res_ins_r;
    res_full_nxt  = res_full_r;
    res_slot_nxt  = res_slot_r;
    mem_we        = 1'b0;
    mem_wa        = clr_addr_r;
    mem_wd        = '0;
    out_load      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          is_ins_nxt = (in_req.req_type == lphs_pkg::REQ_INSERT);
          key_nxt    = in_req.key;
          state_nxt  = ST_HASH;
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          addr_nxt    = mod_rem;
          chk_vld_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // read at addr_r is issued every cycle; data for chk_addr_r arrives now
        addr_nxt     = (addr_r == LAST) ? '0 : addr_r + 1'b1;
        chk_addr_nxt = addr_r;
        chk_vld_nxt  = 1'b1;
        if (chk_vld_r) begin
          res_found_nxt = 1'b0;
          res_ins_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          res_slot_nxt  = '0;
          if (!rd_used) begin
            if (is_ins_r) begin
              mem_we       = 1'b1;
              mem_wa       = chk_addr_r;
              mem_wd       = {1'b1, key_r};
              res_ins_nxt  = 1'b1;
              res_slot_nxt = lphs_pkg::SLOT_W'(chk_addr_r);
            end
            state_nxt = ST_RESP;
          end else if (!is_ins_r && rd_key == key_r) begin
            res_found_nxt = 1'b1;
            res_slot_nxt  = lphs_pkg::SLOT_W'(chk_addr_r);
            state_nxt     = ST_RESP;
          end else if (cnt_r == LAST) begin
            // full pass without a free slot or a match
            res_full_nxt = is_ins_r;
            state_nxt    = ST_RESP;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) out_valid_nxt = 1'b0;
    if (out_load)      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r    <= is_ins_nxt;
    key_r       <= key_nxt;
    addr_r      <= addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    res_found_r <= res_found_nxt;
    res_ins_r   <= res_ins_nxt;
    res_full_r  <= res_full_nxt;
    res_slot_r  <= res_slot_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_ins_r   <= res_ins_r;
      out_full_r  <= res_full_r;
      out_slot_r  <= res_slot_r;
    end
  end

  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.found      = out_found_r;
  assign out_rsp.inserted   = out_ins_r;
  assign out_rsp.table_full = out_full_r;
  assign out_rsp.slot       = out_slot_r;

endmodule
`default_nettype wire

FILE: sv/lphs_mod.sv
// Key-modulo-table-size unit: reciprocal multiply, then one correcting subtract.
`default_nettype none
module lphs_mod #(
  parameter int unsigned TABLE_SIZE = lphs_pkg::TABLE_SIZE_DFLT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lphs_pkg::KEY_W-1:0] key,
  output logic                            done,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] rem
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned KW = lphs_pkg::KEY_W;
  // floor(2^32 / TABLE_SIZE); the quotient estimate comes out low by at most one
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(TABLE_SIZE));
  localparam logic [KW-1:0] DIVK  = KW'(TABLE_SIZE);

  logic [KW-1:0]  key_r, key_nxt;
  logic [KW-1:0]  quo_r, quo_nxt;
  logic [AW-1:0]  rem_r, rem_nxt;
  logic           mul_vld_r, mul_vld_nxt;
  logic           sub_vld_r, sub_vld_nxt;
  logic           done_r, done_nxt;
  logic [KW+31:0] prod;
  logic [KW-1:0]  back;
  logic [KW-1:0]  diff;

  always_comb begin
    prod        = {32'd0, key_r} * {{KW{1'b0}}, RECIP};
    back        = quo_r * DIVK;
    diff        = key_r - back;
    key_nxt     = key_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    mul_vld_nxt = start;
    sub_vld_nxt = mul_vld_r;
    done_nxt    = sub_vld_r;
    if (start) key_nxt = key;
    if (mul_vld_r) quo_nxt = prod[KW+31:32];
    // diff is below twice the table size here
    if (sub_vld_r) rem_nxt = (diff >= DIVK) ? AW'(diff - DIVK) : AW'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      sub_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mul_vld_r <= mul_vld_nxt;
      sub_vld_r <= sub_vld_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire
